[src/ir_pulse_width_classifier_unit_assert.svh]
// Assertion macros shared by the pulse-width classifier RTL.
`ifndef IR_PULSE_WIDTH_CLASSIFIER_UNIT_ASSERT_SVH
`define IR_PULSE_WIDTH_CLASSIFIER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define IRPWC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define IRPWC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/irpwc_pkg.sv]
// Types and constants of the IR pulse-width classifier.
package irpwc_pkg;

    localparam int TimeWidth = 32;
    localparam int CfgWidth  = 16;

    typedef logic [TimeWidth-1:0] time_t;
    typedef logic [CfgWidth-1:0]  cfg_word_t;
    typedef logic [1:0]           class_t;
    typedef logic [1:0]           cfg_index_t;

    // classification codes
    localparam class_t CLASS_NONE = 2'd0;
    localparam class_t CLASS_A    = 2'd1;
    localparam class_t CLASS_B    = 2'd2;

    // register indexes
    localparam cfg_index_t CFG_NOMINAL_A = 2'd0;
    localparam cfg_index_t CFG_NOMINAL_B = 2'd1;
    localparam cfg_index_t CFG_TOLERANCE = 2'd2;
    localparam cfg_index_t CFG_HOLD_TIME = 2'd3;

    typedef struct packed {
        cfg_word_t nominal_a;
        cfg_word_t nominal_b;
        cfg_word_t tolerance;
        cfg_word_t hold_time;
    } cfg_t;

endpackage

[src/irpwc_window.sv]
// Acceptance window test: nominal +/- tolerance, open interval, low bound clamped at 0.
module irpwc_window
    import irpwc_pkg::*;
(
    input  time_t     pulse_len,
    input  cfg_word_t nominal,
    input  cfg_word_t tol,
    output logic      hit
);

    cfg_word_t           lo_bound;
    logic [CfgWidth:0]   hi_bound;

    assign lo_bound = (nominal > tol) ? (nominal - tol) : '0;
    // carry kept: upper bound never wraps
    assign hi_bound = {1'b0, nominal} + {1'b0, tol};

    assign hit = (pulse_len > {{(TimeWidth-CfgWidth){1'b0}}, lo_bound})
              && (pulse_len < {{(TimeWidth-CfgWidth-1){1'b0}}, hi_bound});

endmodule

[src/ir_pulse_width_classifier_unit.sv]
// Top level of the IR pulse-width classifier.
//
// Usage:
//   Input channel (in_valid / in_stall, time_now, pin_level): one transaction per
//   poll of the receiver pin with its millisecond timestamp.
//   Output channel (out_valid / out_stall, identity): one transaction per input
//   transaction, in order: 0 none, 1 type A, 2 type B.
//   Config port (cfg_write, cfg_index, cfg_data): writes type A time, type B time,
//   tolerance and hold time; write only while the block is idle.
// Pipeline:
//   Two stages: an input register, then edge detection, classification and hold
//   check into the result register. out_valid is set when the staged item moves
//   from the input register into the result register; throughput is one
//   transaction per cycle while the receiver keeps out_stall low.
// Reset: rst_n clears the config registers, classifier state and both valid flags;
//   the payload registers are not reset. Stall: a stalled result holds in the output
//   register; the input register keeps filling once, then in_stall rises until the result is taken.
module ir_pulse_width_classifier_unit
    import irpwc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    // input channel
    input  logic       in_valid,
    output logic       in_stall,
    input  time_t      time_now,
    input  logic       pin_level,
    // output channel
    output logic       out_valid,
    input  logic       out_stall,
    output class_t     identity,
    // config port
    input  logic       cfg_write,
    input  cfg_index_t cfg_index,
    input  cfg_word_t  cfg_data
);

    `include "ir_pulse_width_classifier_unit_assert.svh"

    // configuration registers
    cfg_t cfg_reg;

    // stage 1: input register
    logic  s1_valid_reg;
    time_t s1_time_reg;
    logic  s1_pin_reg;

    // classifier state
    logic   prev_level_reg,   prev_level_next;
    time_t  fall_time_reg,    fall_time_next;
    class_t cur_class_reg,    cur_class_next;
    class_t prior_class_reg,  prior_class_next;
    class_t conf_class_reg,   conf_class_next;
    time_t  confirm_time_reg, confirm_time_next;

    // stage 2: result register
    logic   out_valid_reg;
    class_t identity_reg;

    logic   in_accept;
    logic   out_ready;
    logic   advance;
    time_t  pulse_len;
    time_t  since_confirm;
    logic   hit_a;
    logic   hit_b;
    class_t edge_class;

    // handshake
    assign out_ready = !out_valid_reg || !out_stall;
    assign advance   = s1_valid_reg && out_ready;
    assign in_stall  = s1_valid_reg && !out_ready;
    assign in_accept = in_valid && !in_stall;

    assign out_valid = out_valid_reg;
    assign identity  = identity_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_NOMINAL_A: cfg_reg.nominal_a <= cfg_data;
                CFG_NOMINAL_B: cfg_reg.nominal_b <= cfg_data;
                CFG_TOLERANCE: cfg_reg.tolerance <= cfg_data;
                CFG_HOLD_TIME: cfg_reg.hold_time <= cfg_data;
            endcase
        end
    end

    // low-pulse length since the last fall, wrapping
    assign pulse_len = s1_time_reg - fall_time_reg;

    irpwc_window u_window_a (
        .pulse_len (pulse_len),
        .nominal   (cfg_reg.nominal_a),
        .tol       (cfg_reg.tolerance),
        .hit       (hit_a)
    );

    irpwc_window u_window_b (
        .pulse_len (pulse_len),
        .nominal   (cfg_reg.nominal_b),
        .tol       (cfg_reg.tolerance),
        .hit       (hit_b)
    );

    // type A wins on overlap; a miss keeps the old class
    always_comb
    begin
        priority if (hit_a)
            edge_class = CLASS_A;
        else if (hit_b)
            edge_class = CLASS_B;
        else
            edge_class = cur_class_reg;
    end

    always_comb
    begin
        prev_level_next   = prev_level_reg;
        fall_time_next    = fall_time_reg;
        cur_class_next    = cur_class_reg;
        prior_class_next  = prior_class_reg;
        conf_class_next   = conf_class_reg;
        confirm_time_next = confirm_time_reg;

        if (advance)
        begin
            prev_level_next = s1_pin_reg;
            if (s1_pin_reg != prev_level_reg)
            begin
                if (s1_pin_reg)
                begin
                    // rising edge: classify, confirm on two matching rises
                    cur_class_next   = edge_class;
                    prior_class_next = edge_class;
                    if (prior_class_reg == edge_class)
                    begin
                        conf_class_next   = edge_class;
                        confirm_time_next = s1_time_reg;
                    end
                end
                else
                begin
                    fall_time_next = s1_time_reg;
                end
            end
            else
            begin
                cur_class_next = CLASS_NONE;
            end
        end
    end

    // hold expiry, against the confirm time after this poll's update
    assign since_confirm = s1_time_reg - confirm_time_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            prev_level_reg   <= 1'b0;
            fall_time_reg    <= '0;
            cur_class_reg    <= CLASS_NONE;
            prior_class_reg  <= CLASS_NONE;
            conf_class_reg   <= CLASS_NONE;
            confirm_time_reg <= '0;
        end
        else
        begin
            s1_valid_reg     <= in_accept || (s1_valid_reg && !advance);
            out_valid_reg    <= advance || (out_valid_reg && out_stall);
            prev_level_reg   <= prev_level_next;
            fall_time_reg    <= fall_time_next;
            cur_class_reg    <= cur_class_next;
            prior_class_reg  <= prior_class_next;
            confirm_time_reg <= confirm_time_next;
            if (advance && (since_confirm > {{(TimeWidth-CfgWidth){1'b0}}, cfg_reg.hold_time}))
                conf_class_reg <= CLASS_NONE;
            else
                conf_class_reg <= conf_class_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_time_reg <= time_now;
            s1_pin_reg  <= pin_level;
        end
        if (advance)
        begin
            if (since_confirm > {{(TimeWidth-CfgWidth){1'b0}}, cfg_reg.hold_time})
                identity_reg <= CLASS_NONE;
            else
                identity_reg <= conf_class_next;
        end
    end

    `IRPWC_ASSERT_NOW(a_stall_needs_s1, in_stall, s1_valid_reg, "in_stall without pending item")
    `IRPWC_ASSERT_NOW(a_rose_from_s1, $rose(out_valid_reg), $past(s1_valid_reg),
        "result appeared without a staged item")
    `IRPWC_ASSERT_NEXT(a_no_edge_clears, advance && (s1_pin_reg == prev_level_reg),
        cur_class_reg == CLASS_NONE, "class not cleared on a poll with no edge")
    `IRPWC_ASSERT_NEXT(a_fall_records, advance && !s1_pin_reg && prev_level_reg,
        fall_time_reg == $past(s1_time_reg), "fall time not recorded")
    `IRPWC_ASSERT_NOW(a_identity_code, out_valid_reg,
        identity_reg == CLASS_NONE || identity_reg == CLASS_A || identity_reg == CLASS_B,
        "identity carries an unused code")

endmodule

[tb/ir_pulse_width_classifier_checker.sv]
// Channel monitor, identity predictor and result comparison for the pulse-width classifier.
`timescale 1ns / 100ps

module ir_pulse_width_classifier_checker
    import irpwc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  time_t       time_now,
    input  logic        pin_level,
    input  logic        out_valid,
    input  logic        out_stall,
    input  class_t      identity,
    input  logic        cfg_write,
    input  cfg_index_t  cfg_index,
    input  cfg_word_t   cfg_data,
    output int unsigned mismatch_count,
    output int unsigned identities_due
);

    // shadow registers and classifier state
    cfg_t   shadow_cfg;
    logic   last_pin;
    time_t  fall_stamp;
    time_t  confirm_stamp;
    class_t poll_class;
    class_t prev_rise_class;
    class_t held_class;
    class_t expected_identity[$];

    // open window: strictly between clamped low bound and unwrapped high bound
    function automatic logic fits_window(input time_t width, input cfg_word_t nominal,
                                         input cfg_word_t tol);
        logic [16:0] lo;
        logic [16:0] hi;
        lo = (nominal > tol) ? 17'(nominal - tol) : 17'd0;
        hi = 17'(nominal) + 17'(tol);
        return (width > 32'(lo)) && (width < 32'(hi));
    endfunction

    task automatic classify_poll(input time_t now, input logic pin, output class_t result);
        time_t low_width;
        low_width = now - fall_stamp;
        if (pin != last_pin)
        begin
            if (pin)
            begin
                // pulse outside both windows keeps the old class
                if (fits_window(low_width, shadow_cfg.nominal_a, shadow_cfg.tolerance))
                    poll_class = CLASS_A;
                else if (fits_window(low_width, shadow_cfg.nominal_b, shadow_cfg.tolerance))
                    poll_class = CLASS_B;
                if (prev_rise_class == poll_class)
                begin
                    held_class    = poll_class;
                    confirm_stamp = now;
                end
                prev_rise_class = poll_class;
            end
            else
                fall_stamp = now;
        end
        else
            poll_class = CLASS_NONE;
        if (time_t'(now - confirm_stamp) > time_t'(shadow_cfg.hold_time))
            held_class = CLASS_NONE;
        last_pin = pin;
        result   = held_class;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        class_t predicted;
        class_t oldest;
        if (!rst_n)
        begin
            shadow_cfg      = '0;
            last_pin        = 1'b0;
            fall_stamp      = '0;
            confirm_stamp   = '0;
            poll_class      = CLASS_NONE;
            prev_rise_class = CLASS_NONE;
            held_class      = CLASS_NONE;
            mismatch_count  = 0;
            expected_identity.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_identity.size() == 0)
                begin
                    $error("identity: unexpected result, expected none, actual %0d", identity);
                    mismatch_count++;
                end
                else
                begin
                    oldest = expected_identity.pop_front();
                    if (identity !== oldest)
                    begin
                        $error("identity mismatch: expected %0d, actual %0d", oldest, identity);
                        mismatch_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                classify_poll(time_now, pin_level, predicted);
                expected_identity.push_back(predicted);
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_NOMINAL_A: shadow_cfg.nominal_a = cfg_data;
                    CFG_NOMINAL_B: shadow_cfg.nominal_b = cfg_data;
                    CFG_TOLERANCE: shadow_cfg.tolerance = cfg_data;
                    CFG_HOLD_TIME: shadow_cfg.hold_time = cfg_data;
                    default: ;
                endcase
            end
        end
        identities_due = expected_identity.size();
    end

endmodule

[tb/ir_pulse_width_classifier_unit_test.sv]
// Top of the pulse-width classifier test: clock, reset, stimulus, receiver stalls, verdict.
`timescale 1ns / 100ps

module ir_pulse_width_classifier_unit_test;
    import irpwc_pkg::*;

    // every input starts at a known value
    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    time_t      time_now  = '0;
    logic       pin_level = 1'b0;
    logic       out_stall = 1'b0;
    logic       cfg_write = 1'b0;
    cfg_index_t cfg_index = CFG_NOMINAL_A;
    cfg_word_t  cfg_data  = '0;

    logic        in_stall;
    logic        out_valid;
    class_t      identity;
    int unsigned mismatch_count;
    int unsigned identities_due;

    // stimulus bookkeeping
    int unsigned polls_sent      = 0;
    logic        pin_sent        = 1'b0;
    // steady: no idling on either side; pressure_req: one long receiver hold-off
    bit          steady          = 1'b0;
    bit          pressure_req    = 1'b0;
    bit          pressure_served = 1'b0;
    int unsigned hold_off_left   = 0;

    ir_pulse_width_classifier_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .time_now  (time_now),
        .pin_level (pin_level),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .identity  (identity),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ir_pulse_width_classifier_checker identity_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .time_now       (time_now),
        .pin_level      (pin_level),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .identity       (identity),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .identities_due (identities_due)
    );

    always #10 clk = ~clk;

    // Offer one poll transaction. Called at a falling edge; returns at the falling
    // edge after acceptance with in_valid still high, so back-to-back polls never
    // drop valid within one step.
    task automatic send_poll(input time_t stamp, input logic level);
        if (!steady)
            while ($urandom_range(99) < 19)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
        in_valid  <= 1'b1;
        time_now  <= stamp;
        pin_level <= level;
        pin_sent   = level;
        do
            @(posedge clk);
        while (in_stall);
        polls_sent++;
        @(negedge clk);
    endtask

    // Drop valid, wait for every expected identity, then cover the two-stage latency.
    task automatic settle();
        in_valid <= 1'b0;
        while (identities_due != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t index, input cfg_word_t value);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(negedge clk);
    endtask

    // all four registers, back to back; only legal while the block is idle
    task automatic apply_settings(input cfg_word_t a, input cfg_word_t b,
                                  input cfg_word_t tol, input cfg_word_t hold);
        write_reg(CFG_NOMINAL_A, a);
        write_reg(CFG_NOMINAL_B, b);
        write_reg(CFG_TOLERANCE, tol);
        write_reg(CFG_HOLD_TIME, hold);
        cfg_write <= 1'b0;
    endtask

    // pulse length scattered over a window plus one step past each bound
    function automatic int unsigned near_window(input cfg_word_t nominal, input cfg_word_t tol);
        int v;
        v = int'(nominal) + int'($urandom_range(0, 2 * 32'(tol) + 2)) - int'(tol) - 1;
        return (v < 0) ? 0 : v;
    endfunction

    // Mostly well-formed pulses (high polls, fall, optional low poll, rise) with
    // lengths aimed at the windows and their bounds; about one pulse in ten is a noise poll.
    task automatic run_phase(input cfg_word_t a, input cfg_word_t b, input cfg_word_t tol,
                             input cfg_word_t hold, input int unsigned polls);
        time_t       stamp;
        time_t       fall_at;
        int unsigned pulse_len;
        int unsigned gap;
        int unsigned stop_at;
        apply_settings(a, b, tol, hold);
        stop_at = polls_sent + polls;
        // random start reaches the upper timestamp bits and the wrap
        stamp = $urandom;
        while (polls_sent < stop_at)
        begin
            // now and then a gap long enough to let the hold expire
            gap = ($urandom_range(9) == 0) ? $urandom_range(0, 2 * 32'(hold) + 2)
                                           : $urandom_range(0, 40);
            if ($urandom_range(99) < 10)
                send_poll($urandom, 1'($urandom_range(1)));
            else
            begin
                if (!pin_sent)
                begin
                    stamp += gap;
                    send_poll(stamp, 1'b1);
                end
                repeat ($urandom_range(0, 2))
                begin
                    stamp += $urandom_range(0, 30);
                    send_poll(stamp, 1'b1);
                end
                stamp += gap + 1;
                send_poll(stamp, 1'b0);
                fall_at = stamp;
                case ($urandom_range(4))
                    0: pulse_len = near_window(a, tol);
                    1: pulse_len = near_window(b, tol);
                    2: pulse_len = $urandom_range(0, 200000);
                    3: pulse_len = $urandom_range(1) ? 32'(a) + 32'(tol)
                                 : ((a > tol) ? 32'(a - tol) : 0);
                    default: pulse_len = $urandom_range(0, 3);
                endcase
                // a low poll inside the pulse clears the running class
                if (pulse_len > 1 && $urandom_range(1))
                    send_poll(fall_at + $urandom_range(1, pulse_len - 1), 1'b0);
                stamp = fall_at + pulse_len;
                send_poll(stamp, 1'b1);
            end
        end
        settle();
    endtask

    // Receiver: random stalls, plus one long hold-off counted here so the input
    // register fills and in_stall has to rise.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (pressure_req && !pressure_served)
            begin
                pressure_served = 1'b1;
                hold_off_left   = 60;
            end
            if (hold_off_left != 0)
            begin
                hold_off_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !steady && ($urandom_range(99) < 19);
        end
    end

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: A 100, B 300, tolerance 20, hold 1000
        apply_settings(16'd100, 16'd300, 16'd20, 16'd1000);
        send_poll(32'd0, 1'b0);            // timestamp zero, no edge
        send_poll(32'd10, 1'b1);           // short pulse: class 0 twice, confirms none
        send_poll(32'd20, 1'b0);
        send_poll(32'd120, 1'b1);          // type A
        send_poll(32'd130, 1'b0);
        send_poll(32'd230, 1'b1);          // type A again, confirmed
        send_poll(32'd240, 1'b1);          // no edge
        send_poll(32'd250, 1'b0);
        send_poll(32'd550, 1'b1);          // type B
        send_poll(32'd560, 1'b0);
        send_poll(32'd860, 1'b1);          // type B confirmed
        send_poll(32'd870, 1'b0);
        send_poll(32'd950, 1'b1);          // exactly on lower bound: old class kept
        send_poll(32'd5000, 1'b1);         // hold expired
        send_poll(32'hFFFF_FFF0, 1'b0);    // fall just before the wrap
        send_poll(32'hFFFF_FFFF, 1'b0);    // all ones, no edge
        send_poll(32'h0000_0054, 1'b1);    // wrapped length 100: type A
        settle();

        // overlapping windows, tolerance above nominal so the low bound clamps at zero
        apply_settings(16'd10, 16'd10, 16'd50, 16'hFFFF);
        send_poll(32'd1000, 1'b0);
        send_poll(32'd1000, 1'b1);         // zero length fails the clamped bound
        send_poll(32'd1010, 1'b0);
        send_poll(32'd1011, 1'b1);         // in both windows: type A wins
        send_poll(32'd1012, 1'b0);
        send_poll(32'd1072, 1'b1);         // exactly on upper bound: outside
        settle();

        // random phases across settings, extremes among them
        run_phase(16'd100, 16'd300, 16'd20, 16'd1000, 120);
        run_phase(16'd10, 16'd10, 16'd50, 16'hFFFF, 120);
        steady = 1'b1;
        run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 120);
        steady = 1'b0;
        run_phase(16'd0, 16'd0, 16'd0, 16'd0, 120);
        pressure_req = 1'b1;
        run_phase(16'($urandom_range(1, 2000)), 16'($urandom_range(1, 2000)),
                  16'($urandom_range(0, 300)), 16'($urandom_range(0, 5000)), 120);
        run_phase(16'd500, 16'd1500, 16'd100, 16'd0, 120);

        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
